[src/linear_probe_hash_table_unit_assert.svh]
// assertion macros for the hash table unit
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define LPHT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPHT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lpht_pkg.sv]
`default_nettype none

package lpht_pkg;

    localparam int SLOT_W      = 8;
    localparam int TABLE_SLOTS = 1 << SLOT_W;
    localparam int CNT_W       = SLOT_W + 1;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int ENTRY_W     = KEY_W + DATA_W + 2;

    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 56;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DONE,
        S_CLEAR
    } state_t;

endpackage

`default_nettype wire

[src/linear_probe_hash_table_unit.sv]
// Open-addressing hash table of TABLE_SLOTS (256) slots with linear probing
// and tombstones. Each input item is an insert, find or remove; each gives
// exactly one result item with status, slot index, stored data and the live
// entry count. Key, data word, occupied flag and tombstone flag of every slot
// live together in one synchronous simple dual-port memory with a registered
// read. After reset a clearing pass writes every slot empty, one slot per
// cycle, so s_tready stays low until all TABLE_SLOTS (256) slots are clear.
// An operation is accepted in S_IDLE, probes 1 to TABLE_SLOTS slots one at
// a time in S_CHECK (one memory read each) and hands over its result in
// S_DONE; an unused mode value skips S_CHECK. One item is in work at a time;
// a new item is accepted once the previous result has moved to the output
// register, which then waits for m_tready on its own.
`default_nettype none

module linear_probe_hash_table_unit
    import lpht_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // mode[1:0], key[33:2], data_value[65:34], zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status[1:0], slot_index[9:2], stored_data[41:10], entry_count[50:42], zero fill
    output logic [M_TDATA_W-1:0]      m_tdata
);

    state_t state_reg, state_next;

    logic [1:0]        op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [DATA_W-1:0] dval_reg, dval_next;
    logic [SLOT_W-1:0] probe_reg, probe_next;
    logic [SLOT_W-1:0] n_reg, n_next;
    logic              have_free_reg, have_free_next;
    logic [SLOT_W-1:0] free_reg, free_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;

    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [1:0]        res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [DATA_W-1:0] res_data_reg, res_data_next;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_status_reg;
    logic [7:0]        m_slot_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic [8:0]        m_cnt_reg;

    // tombstone, occupied, data, key
    logic [ENTRY_W-1:0] kv_mem [TABLE_SLOTS];
    logic [ENTRY_W-1:0] rd_reg;
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic [1:0]        in_mode;
    logic [KEY_W-1:0]  in_key;
    logic [DATA_W-1:0] in_dval;
    logic              accept;
    logic              out_free;

    logic              cur_occ, cur_free, cur_never, hit, last_probe, stop;
    logic              have_free_now;
    logic [SLOT_W-1:0] free_now;

    assign in_mode  = s_tdata[1:0];
    assign in_key   = s_tdata[KEY_W+1:2];
    assign in_dval  = s_tdata[KEY_W+DATA_W+1:KEY_W+2];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign cur_occ       = rd_reg[KEY_W+DATA_W];
    assign cur_free      = !cur_occ;
    assign cur_never     = cur_free && !rd_reg[KEY_W+DATA_W+1];
    assign hit           = cur_occ && (rd_reg[KEY_W-1:0] == key_reg);
    assign last_probe    = (n_reg == {SLOT_W{1'b1}});
    assign stop          = hit || cur_never || last_probe;
    assign have_free_now = have_free_reg || cur_free;
    assign free_now      = have_free_reg ? free_reg : probe_reg;

    assign rd_addr = (state_reg == S_CHECK) ? probe_next : in_key[SLOT_W-1:0];

    always_ff @(posedge aclk) begin
        rd_reg <= kv_mem[rd_addr];
        if (wr_en) begin
            kv_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        dval_reg       <= dval_next;
        probe_reg      <= probe_next;
        n_reg          <= n_next;
        have_free_reg  <= have_free_next;
        free_reg       <= free_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_data_reg   <= res_data_next;
        if (state_reg == S_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= 8'(res_slot_reg);
            m_data_reg   <= res_data_reg;
            m_cnt_reg    <= 9'(cnt_reg);
        end
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        dval_next       = dval_reg;
        probe_next      = probe_reg;
        n_next          = n_reg;
        have_free_next  = have_free_reg;
        free_next       = free_reg;
        clr_next        = clr_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_data_next   = res_data_reg;
        m_valid_next    = m_valid_reg;
        wr_en           = 1'b0;
        wr_addr         = free_now;
        wr_data         = {2'b01, dval_reg, key_reg};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {SLOT_W{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    op_next         = in_mode;
                    key_next        = in_key;
                    dval_next       = in_dval;
                    probe_next      = in_key[SLOT_W-1:0];
                    n_next          = '0;
                    have_free_next  = 1'b0;
                    free_next       = '0;
                    res_status_next = ST_MISS;
                    res_slot_next   = '0;
                    res_data_next   = '0;
                    if (in_mode == MODE_INSERT || in_mode == MODE_FIND ||
                        in_mode == MODE_REMOVE) begin
                        state_next = S_CHECK;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CHECK: begin
                if (!stop) begin
                    probe_next     = probe_reg + 1'b1;
                    n_next         = n_reg + 1'b1;
                    have_free_next = have_free_now;
                    free_next      = free_now;
                end else begin
                    state_next = S_DONE;
                    case (op_reg)
                        MODE_INSERT: begin
                            if (hit) begin
                                res_status_next = ST_DUP;
                            end else if (!have_free_now) begin
                                res_status_next = ST_FULL;
                            end else begin
                                wr_en           = 1'b1;
                                cnt_next        = cnt_reg + 1'b1;
                                res_status_next = ST_OK;
                                res_slot_next   = free_now;
                            end
                        end
                        MODE_FIND: begin
                            if (hit) begin
                                res_status_next = ST_OK;
                                res_slot_next   = probe_reg;
                                res_data_next   = rd_reg[KEY_W+DATA_W-1:KEY_W];
                            end
                        end
                        MODE_REMOVE: begin
                            if (hit) begin
                                wr_en   = 1'b1;
                                wr_addr = probe_reg;
                                wr_data = {2'b10, rd_reg[KEY_W+DATA_W-1:0]};
                                if (cnt_reg != '0) begin
                                    cnt_next = cnt_reg - 1'b1;
                                end
                                res_status_next = ST_OK;
                                res_slot_next   = probe_reg;
                            end
                        end
                        default: begin
                            res_status_next = ST_MISS;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_cnt_reg, m_data_reg, m_slot_reg, m_status_reg};

    `include "linear_probe_hash_table_unit_assert.svh"

    `LPHT_ASSERT_NXT(a_bad_mode_done,
        accept && in_mode != MODE_INSERT && in_mode != MODE_FIND && in_mode != MODE_REMOVE,
        state_reg == S_DONE, "unused mode must go straight to result")
    `LPHT_ASSERT_NXT(a_insert_count,
        wr_en && state_reg == S_CHECK && op_reg == MODE_INSERT,
        cnt_reg == $past(cnt_reg) + 1'b1, "insert must raise entry count")
    `LPHT_ASSERT_IMP(a_fail_slot_zero,
        m_tvalid && m_tdata[1:0] != ST_OK, m_tdata[9:2] == 8'd0,
        "failed operation must report slot zero")

endmodule

`default_nettype wire

[tb/linear_probe_hash_table_unit_checker.sv]
module linear_probe_hash_table_unit_checker
    import lpht_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    output int                        fail_count,
    output int                        open_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // low bits first: status, slot, data, count
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] data;
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } table_reply_t;

    bit                slot_live [TABLE_SLOTS];
    bit                slot_dead [TABLE_SLOTS];
    logic [KEY_W-1:0]  slot_key  [TABLE_SLOTS];
    logic [DATA_W-1:0] slot_word [TABLE_SLOTS];
    int                live_count;

    table_reply_t      expected_replies [$];
    table_reply_t      want;
    table_reply_t      got;
    int                mismatches = 0;

    initial begin
        fail_count = 0;
        open_count = 0;
    end

    function automatic int home_slot(input logic [KEY_W-1:0] key);
        return int'(key % KEY_W'(TABLE_SLOTS));
    endfunction

    // search past other keys and tombstones, stop at a never-used slot
    function automatic bit find_live(input logic [KEY_W-1:0] key, output int where);
        int s;
        s = home_slot(key);
        where = 0;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            if (slot_live[s]) begin
                if (slot_key[s] == key) begin
                    where = s;
                    return 1'b1;
                end
            end else if (!slot_dead[s]) begin
                return 1'b0;
            end
            s = (s + 1) % TABLE_SLOTS;
        end
        return 1'b0;
    endfunction

    function automatic table_reply_t apply_table_op(input logic [1:0] op_bits,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [DATA_W-1:0] value);
        table_reply_t r;
        int           s;
        int           free_at;
        bit           have_free;
        bit           dup;
        r = '0;
        r.status = ST_MISS;
        case (mode_t'(op_bits))
            MODE_INSERT: begin
                have_free = 1'b0;
                dup = 1'b0;
                free_at = 0;
                s = home_slot(key);
                for (int n = 0; n < TABLE_SLOTS; n++) begin
                    if (slot_live[s]) begin
                        if (slot_key[s] == key) begin
                            dup = 1'b1;
                            break;
                        end
                    end else begin
                        if (!have_free) begin
                            have_free = 1'b1;
                            free_at = s;
                        end
                        if (!slot_dead[s])
                            break;
                    end
                    s = (s + 1) % TABLE_SLOTS;
                end
                if (dup) begin
                    r.status = ST_DUP;
                end else if (!have_free) begin
                    r.status = ST_FULL;
                end else begin
                    slot_live[free_at] = 1'b1;
                    slot_dead[free_at] = 1'b0;
                    slot_key[free_at] = key;
                    slot_word[free_at] = value;
                    live_count++;
                    r.status = ST_OK;
                    r.slot = SLOT_W'(free_at);
                end
            end
            MODE_FIND: begin
                if (find_live(key, s)) begin
                    r.status = ST_OK;
                    r.slot = SLOT_W'(s);
                    r.data = slot_word[s];
                end
            end
            MODE_REMOVE: begin
                if (find_live(key, s)) begin
                    slot_live[s] = 1'b0;
                    slot_dead[s] = 1'b1;
                    if (live_count > 0)
                        live_count--;
                    r.status = ST_OK;
                    r.slot = SLOT_W'(s);
                end
            end
            default: begin
            end
        endcase
        r.count = CNT_W'(live_count);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (slot_live[i]) begin
                slot_live[i] = 1'b0;
                slot_dead[i] = 1'b0;
            end
            live_count = 0;
            expected_replies.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = table_reply_t'(m_tdata[$bits(table_reply_t)-1:0]);
                if (expected_replies.size() == 0) begin
                    $error("result item with nothing expected: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.slot !== want.slot) begin
                        $error("slot_index: expected %0d, actual %0d", want.slot, got.slot);
                        mismatches++;
                    end
                    if (got.data !== want.data) begin
                        $error("stored_data: expected %h, actual %h", want.data, got.data);
                        mismatches++;
                    end
                    if (got.count !== want.count) begin
                        $error("entry_count: expected %0d, actual %0d", want.count, got.count);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_replies.push_back(apply_table_op(s_tdata[1:0], s_tdata[33:2],
                                                          s_tdata[65:34]));
        end
        fail_count <= mismatches;
        open_count <= expected_replies.size();
    end

endmodule

[tb/linear_probe_hash_table_unit_test.sv]
module linear_probe_hash_table_unit_test;
    import lpht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // mode[1:0], key[33:2], data_value[65:34], zero fill
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // status[1:0], slot_index[9:2], stored_data[41:10], entry_count[50:42], zero fill
    logic [M_TDATA_W-1:0] m_tdata;

    int                   fail_count;
    int                   open_count;
    int                   results_seen = 0;
    bit                   quiet = 1'b0;

    logic [KEY_W-1:0]     key_pool [40];
    logic [KEY_W-1:0]     filled_keys [$];

    linear_probe_hash_table_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    linear_probe_hash_table_unit_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            results_seen <= results_seen + 1;
    end

    // valid stays high between back-to-back items
    task automatic send_item(input logic [1:0] mode, input logic [KEY_W-1:0] key,
                             input logic [DATA_W-1:0] value);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'({value, key, mode});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_table_ops();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (open_count != 0) @(posedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return $urandom();
        if (r < 40 && filled_keys.size() != 0)
            return filled_keys[$urandom_range(0, filled_keys.size() - 1)];
        return key_pool[$urandom_range(0, 39)];
    endfunction

    task automatic mixed_ops(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_item(MODE_INSERT, pick_key(), $urandom());
            else if (r < 70)
                send_item(MODE_FIND, pick_key(), $urandom());
            else if (r < 95)
                send_item(MODE_REMOVE, pick_key(), $urandom());
            else
                send_item(MODE_UNUSED, pick_key(), $urandom());
        end
    endtask

    initial begin : result_sink
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            if (!hold_done && results_seen >= 150) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 6);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        logic [31:0] tmp;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 40; i++) begin
            tmp = $urandom();
            if (i % 2 == 0)
                key_pool[i] = {tmp[31:8], 8'(252 + $urandom_range(0, 7))};
            else
                key_pool[i] = tmp;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // collisions on home slot 0, wrap from the last slot, tombstones
        send_item(MODE_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_INSERT, 32'h0000_0000, 32'h1234_5678);
        send_item(MODE_INSERT, 32'h0000_0100, 32'hA5A5_A5A5);
        send_item(MODE_INSERT, 32'h0000_01FF, 32'h5A5A_5A5A);
        send_item(MODE_FIND, 32'h0000_0100, 32'hFFFF_FFFF);
        send_item(MODE_FIND, 32'h0000_01FF, 32'h0000_0000);
        send_item(MODE_FIND, 32'h0000_0200, 32'h0000_0000);
        send_item(MODE_REMOVE, 32'h0000_0100, 32'h0000_0000);
        send_item(MODE_FIND, 32'h0000_01FF, 32'h0000_0000);
        send_item(MODE_REMOVE, 32'h0000_0100, 32'h0000_0000);
        send_item(MODE_INSERT, 32'h0000_01FF, 32'hDEAD_BEEF);
        send_item(MODE_INSERT, 32'h0000_0300, 32'hC0FF_EE00);
        send_item(MODE_FIND, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(MODE_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_FIND, 32'h0000_0000, 32'h0000_0000);
        send_item(MODE_INSERT, 32'h0000_0000, 32'h8000_0001);
        send_item(MODE_FIND, 32'h0000_0000, 32'h0000_0000);
        drain_table_ops();

        mixed_ops(300);
        drain_table_ops();

        // fill until the table reports full
        for (int i = 0; i < 280; i++) begin
            tmp = $urandom();
            filled_keys.push_back(tmp);
            send_item(MODE_INSERT, tmp, $urandom());
        end
        for (int i = 0; i < 20; i++)
            send_item(MODE_FIND, $urandom(), $urandom());
        for (int i = 0; i < 10; i++)
            send_item(MODE_FIND, filled_keys[$urandom_range(0, 279)], $urandom());
        for (int i = 0; i < 10; i++)
            send_item(MODE_INSERT, key_pool[$urandom_range(0, 39)], $urandom());
        drain_table_ops();

        for (int i = 0; i < 200; i++)
            send_item(MODE_REMOVE, filled_keys[i], $urandom());

        mixed_ops(100);
        quiet = 1'b1;
        mixed_ops(60);

        drain_table_ops();
        repeat (300) @(posedge aclk);
        if (fail_count == 0 && open_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #4_500_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[linear_probe_hash_table_unit.f]
+incdir+src
src/lpht_pkg.sv
src/linear_probe_hash_table_unit.sv
tb/linear_probe_hash_table_unit_checker.sv
tb/linear_probe_hash_table_unit_test.sv
